// ===== hdl/itd_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package itd_pkg;

  // Default word width and fixed field widths.
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  // ASCII codes, truncated to the six bits of the character field.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } itd_state_t;

  // Control broadcast from the sequencer to every digit cell.
  typedef struct packed {
    logic clear;
    logic bin_shift;
    logic dig_shift;
  } cell_ctl_t;

endpackage : itd_pkg

`default_nettype wire

// ===== hdl/int_to_decimal_ascii.sv =====
// Top level: binary word to decimal ASCII characters, MSD first.
// After acceptance busy stays high through the bit-serial shift through the cell chain and the
// digit walk, and a new transaction is taken only while busy is low.
// A minus sign appears the cycle after acceptance; the digits follow one per cycle, and the
// last character is on the ports when busy is low again.
// The receiver cannot stall. Synchronous reset returns the sequencer to idle and drops the strobe.
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = itd_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire                         operation,
  input  wire [VALUE_WIDTH-1:0]       value,
  output logic                        busy,
  output logic                        strobe,
  output logic [itd_pkg::CHAR_W-1:0]  character,
  output logic                        last
);
  import itd_pkg::*;

  // Decimal digits needed for the largest unsigned word.
  localparam int NumDigits = VALUE_WIDTH * 30103 / 100000 + 1;

  cell_ctl_t          ctl;
  logic               bin_bit;
  logic [DIGIT_W-1:0] digits [NumDigits];
  logic               carries [NumDigits];

  // Sequencer.
  itd_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NumDigits)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .value     (value),
    .top_digit (digits[NumDigits-1]),
    .busy      (busy),
    .ctl       (ctl),
    .bin_bit   (bin_bit),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  // Digit cell chain, units digit at index zero.
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_first
      itd_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (bin_bit),
        .digit_in  ('0),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end else begin : g_rest
      itd_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (carries[i-1]),
        .digit_in  (digits[i-1]),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end
  end

endmodule : int_to_decimal_ascii

`default_nettype wire

// ===== hdl/itd_cell.sv =====
// One BCD digit cell of the shift-and-add-3 converter chain.
`timescale 1ns / 1ps
`default_nettype none

module itd_cell (
  input  wire                          clk,
  input  wire itd_pkg::cell_ctl_t      ctl,
  input  wire                          carry_in,
  input  wire [itd_pkg::DIGIT_W-1:0]   digit_in,
  output logic                         carry_out,
  output logic [itd_pkg::DIGIT_W-1:0]  digit
);
  import itd_pkg::*;

  logic [DIGIT_W-1:0] adjusted;

  // Add three before the shift when the digit would overflow past nine.
  always_comb begin
    if (digit >= DIGIT_W'(5)) begin
      adjusted = digit + DIGIT_W'(3);
    end else begin
      adjusted = digit;
    end
    carry_out = adjusted[DIGIT_W-1];
  end

  // Binary mode shifts one bit up the chain; digit mode moves whole digits up.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.bin_shift) begin
      digit <= {adjusted[DIGIT_W-2:0], carry_in};
    end else if (ctl.dig_shift) begin
      digit <= digit_in;
    end
  end

endmodule : itd_cell

`default_nettype wire

// ===== hdl/itd_ctrl.sv =====
// Sequencer: input capture, magnitude shifter, digit walk and character output.
`timescale 1ns / 1ps
`default_nettype none

module itd_ctrl #(
  parameter int VALUE_WIDTH = itd_pkg::DEFAULT_VALUE_WIDTH,
  parameter int NUM_DIGITS  = 10
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire                          operation,
  input  wire [VALUE_WIDTH-1:0]        value,
  input  wire [itd_pkg::DIGIT_W-1:0]   top_digit,
  output logic                         busy,
  output itd_pkg::cell_ctl_t           ctl,
  output logic                         bin_bit,
  output logic                         strobe,
  output logic [itd_pkg::CHAR_W-1:0]   character,
  output logic                         last
);
  import itd_pkg::*;

  localparam int BitCntW = $clog2(VALUE_WIDTH + 1);
  localparam int DigCntW = $clog2(NUM_DIGITS + 1);

  itd_state_t            state, state_next;
  logic [VALUE_WIDTH-1:0] mag, mag_next;
  logic [BitCntW-1:0]    bit_cnt, bit_cnt_next;
  logic [DigCntW-1:0]    remaining, remaining_next;
  logic                  strobe_next;
  logic [CHAR_W-1:0]     character_next;
  logic                  last_next;
  logic                  accept;
  logic                  negative;
  logic                  top_is_zero;
  logic                  final_digit;

  assign accept      = start && (state == ST_IDLE);
  assign negative    = operation && value[VALUE_WIDTH-1];
  assign top_is_zero = (top_digit == '0);
  assign final_digit = (remaining == DigCntW'(1));
  assign busy        = (state != ST_IDLE);
  assign bin_bit     = mag[VALUE_WIDTH-1];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (bit_cnt == '0) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!top_is_zero || final_digit) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (final_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and output register values.
  always_comb begin
    ctl            = '0;
    mag_next       = mag;
    bit_cnt_next   = bit_cnt;
    remaining_next = remaining;
    strobe_next    = 1'b0;
    character_next = character;
    last_next      = last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          // The minus sign goes out while the conversion starts.
          ctl.clear      = 1'b1;
          mag_next       = negative ? (~value + VALUE_WIDTH'(1)) : value;
          bit_cnt_next   = BitCntW'(VALUE_WIDTH - 1);
          remaining_next = DigCntW'(NUM_DIGITS);
          strobe_next    = negative;
          character_next = ASCII_MINUS;
          last_next      = 1'b0;
        end
      end
      ST_CONVERT: begin
        ctl.bin_shift = 1'b1;
        mag_next      = {mag[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_next  = bit_cnt - BitCntW'(1);
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the units digit.
        if (top_is_zero && !final_digit) begin
          ctl.dig_shift  = 1'b1;
          remaining_next = remaining - DigCntW'(1);
        end
      end
      ST_EMIT: begin
        ctl.dig_shift  = 1'b1;
        remaining_next = remaining - DigCntW'(1);
        strobe_next    = 1'b1;
        character_next = ASCII_ZERO | CHAR_W'(top_digit);
        last_next      = final_digit;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag       <= mag_next;
    bit_cnt   <= bit_cnt_next;
    remaining <= remaining_next;
    character <= character_next;
    last      <= last_next;
  end

endmodule : itd_ctrl

`default_nettype wire

// ===== tb/sv/tb_int_to_decimal_ascii.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii;

  import itd_pkg::*;

  localparam int WIDTH          = DEFAULT_VALUE_WIDTH;
  localparam int RANDOM_NUMBERS = 88;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // How the word is read.
  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } format_op_t;

  // One emitted character as the block presents it.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } ascii_char_t;

  // One row of the directed table; an empty text means the predictor decides.
  typedef struct {
    format_op_t       op;
    logic [WIDTH-1:0] word;
    string            text;
  } number_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             operation = 1'b0;
  logic [WIDTH-1:0] value = '0;
  logic             busy;
  logic             strobe;
  logic [CHAR_W-1:0] character;
  logic             last;

  ascii_char_t expected_chars[$];
  number_row_t directed_rows[$];

  int numbers_sent   = 0;
  int signed_sent    = 0;
  int chars_checked  = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  int_to_decimal_ascii #(
    .VALUE_WIDTH(WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  // Free-running clock, 20 ns period.
  initial begin
    forever #10 clk = ~clk;
  end

  // Queue the characters of the decimal form of a word, most significant first.
  function automatic void predict_decimal(input format_op_t op, input logic [WIDTH-1:0] word);
    logic [WIDTH-1:0] magnitude;
    logic [3:0]       digits[0:23];
    int               count;
    ascii_char_t      ch;
    magnitude = word;
    count = 0;
    if (op == OP_SIGNED && word[WIDTH-1]) begin
      // The most negative word wraps to its own magnitude as an unsigned value.
      magnitude = ~word + 1'b1;
      ch.character = ASCII_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    if (magnitude == '0) begin
      digits[0] = 4'd0;
      count = 1;
    end else begin
      while (magnitude != '0) begin
        digits[count] = 4'(magnitude % 10);
        magnitude = magnitude / 10;
        count++;
      end
    end
    for (int i = count - 1; i >= 0; i--) begin
      ch.character = ASCII_ZERO + CHAR_W'(digits[i]);
      ch.last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // Queue characters typed in as text; the final one carries the last flag.
  function automatic void push_text(input string text);
    ascii_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.character = CHAR_W'(text[i]);
      ch.last = (i == text.len() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void add_row(input format_op_t op, input logic [WIDTH-1:0] word,
                                  input string text);
    number_row_t row;
    row.op = op;
    row.word = word;
    row.text = text;
    directed_rows.push_back(row);
  endfunction

  // Present one number and hold it until the block takes it; start stays high.
  task automatic send_number(input format_op_t op, input logic [WIDTH-1:0] word,
                             input string text);
    start <= 1'b1;
    operation <= op;
    value <= word;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (text.len() == 0) predict_decimal(op, word);
    else push_text(text);
    numbers_sent++;
    if (op == OP_SIGNED) signed_sent++;
  endtask

  // Lower start and let a number of cycles pass; a zero gap keeps start high.
  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Lower start and wait until every queued character has come out.
  task automatic wait_all_chars;
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Pick a random word from one of several value classes.
  function automatic logic [WIDTH-1:0] random_word();
    logic [WIDTH-1:0] power;
    logic [WIDTH-1:0] word;
    int               exponent;
    case ($urandom_range(0, 5))
      0, 5: word = $urandom;
      1: word = $urandom_range(0, 999);
      2: begin
        // Around a power of ten, where the digit count changes.
        exponent = $urandom_range(0, 9);
        power = 1;
        for (int i = 0; i < exponent; i++) power = power * 10;
        word = power + $urandom_range(0, 2) - 1;
      end
      3: word = -$urandom_range(1, 1000);
      default: begin
        // Near the signed and unsigned extremes.
        case ($urandom_range(0, 3))
          0: word = 32'h7FFF_FFFF;
          1: word = 32'h8000_0000;
          2: word = 32'hFFFF_FFFF;
          default: word = 32'h0000_0000;
        endcase
        word = word + $urandom_range(0, 4) - 2;
      end
    endcase
    return word;
  endfunction

  // Compare each emitted character with the oldest expectation.
  always @(posedge clk) begin
    ascii_char_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Unexpected character %0d last %0b at %0t", character, last, $realtime);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (character !== want.character || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch at %0t: character exp %0d got %0d, last exp %0b got %0b",
                     $realtime, want.character, character, want.last, last);
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction and no character is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d characters outstanding", expected_chars.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, then random bursts.
  initial begin
    int burst_len;
    int sent;

    add_row(OP_UNSIGNED, 32'h0000_0000, "0");
    add_row(OP_SIGNED,   32'h0000_0000, "0");
    add_row(OP_UNSIGNED, 32'hFFFF_FFFF, "4294967295");
    add_row(OP_SIGNED,   32'hFFFF_FFFF, "-1");
    add_row(OP_SIGNED,   32'h8000_0000, "-2147483648");
    add_row(OP_UNSIGNED, 32'h8000_0000, "2147483648");
    add_row(OP_SIGNED,   32'h7FFF_FFFF, "2147483647");
    add_row(OP_UNSIGNED, 32'h7FFF_FFFF, "2147483647");
    add_row(OP_UNSIGNED, 32'h0000_0001, "1");
    add_row(OP_SIGNED,   32'h0000_0001, "1");
    add_row(OP_UNSIGNED, 32'h0000_0009, "9");
    add_row(OP_UNSIGNED, 32'h0000_000A, "10");
    add_row(OP_UNSIGNED, 32'h3B9A_CA00, "1000000000");
    add_row(OP_SIGNED,   32'hFFFF_FFF6, "-10");
    add_row(OP_SIGNED,   32'h8000_0001, "");
    add_row(OP_UNSIGNED, 32'h3B9A_C9FF, "");
    add_row(OP_SIGNED,   32'h00BC_614E, "");
    add_row(OP_SIGNED,   32'hDEAD_BEEF, "");
    add_row(OP_UNSIGNED, 32'hDEAD_BEEF, "");
    add_row(OP_UNSIGNED, 32'h5555_5555, "");
    add_row(OP_SIGNED,   32'hAAAA_AAAA, "");
    add_row(OP_UNSIGNED, 32'hEE6B_2800, "");

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: the first half back to back, the rest with short gaps.
    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].op, directed_rows[i].word, directed_rows[i].text);
      if (i >= directed_rows.size() / 2) sender_gap($urandom_range(0, 3));
    end

    // Let the block run dry before the random part.
    wait_all_chars();

    // Random bursts with random gaps; one mid-run pause until empty.
    sent = 0;
    while (sent < RANDOM_NUMBERS) begin
      burst_len = $urandom_range(1, 8);
      for (int b = 0; b < burst_len && sent < RANDOM_NUMBERS; b++) begin
        send_number(format_op_t'($urandom_range(0, 1)), random_word(), "");
        sent++;
      end
      if (sent >= RANDOM_NUMBERS / 2 && sent - burst_len < RANDOM_NUMBERS / 2)
        wait_all_chars();
      else if ($urandom_range(0, 3) == 0)
        sender_gap(0);
      else
        sender_gap($urandom_range(1, 60));
    end

    // Drain and allow for any stray character.
    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) begin
      mismatch_count++;
      $display("%0d characters never arrived", expected_chars.size());
    end

    $display("Converted %0d numbers (%0d signed, %0d unsigned) and checked %0d characters,",
             numbers_sent, signed_sent, numbers_sent - signed_sent, chars_checked);
    $display("covering zero, both extremes, digit-count boundaries and random words.");

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
